// File: hw/rtl/dual_axis_incremental_pi_unit_macros.svh
// Assertion helpers for the checker.
`ifndef DUAL_AXIS_INCREMENTAL_PI_UNIT_MACROS_SVH
`define DUAL_AXIS_INCREMENTAL_PI_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define DAPI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define DAPI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/dapi_pkg.sv
package dapi_pkg;

    localparam int GAIN_W  = 24;
    localparam int DATA_W  = 24;
    localparam int ERR_W   = DATA_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int FRAC_W  = 12;
    localparam int PROD_P_W = DIFF_W + GAIN_W + 1;
    localparam int PROD_I_W = ERR_W + GAIN_W + 1;
    localparam int P_W     = PROD_P_W - FRAC_W;
    localparam int I_W     = PROD_I_W - FRAC_W;
    localparam int SUM_W   = P_W + 2;
    localparam int Q_FRAC  = 8;
    localparam int DRIVE_W = 16;
    localparam int NUM_REGS = 8;
    localparam int IDX_W   = 3;

    localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(64'sd8388607);
    localparam logic signed [SUM_W-1:0] OUT_MIN = SUM_W'(-64'sd8388608);
    localparam logic signed [SUM_W-1:0] DRIVE_MAX = SUM_W'(64'sd32767);
    localparam logic signed [SUM_W-1:0] DRIVE_MIN = SUM_W'(-64'sd32767);
    localparam logic signed [SUM_W-1:0] ROUND_ADJ = SUM_W'(64'sd255);

    typedef enum logic [IDX_W-1:0] {
        REG_ROLL_RATE_KP   = 3'd0,
        REG_ROLL_RATE_KI   = 3'd1,
        REG_ROLL_ANGLE_KP  = 3'd2,
        REG_ROLL_ANGLE_KI  = 3'd3,
        REG_PITCH_RATE_KP  = 3'd4,
        REG_PITCH_RATE_KI  = 3'd5,
        REG_PITCH_ANGLE_KP = 3'd6,
        REG_PITCH_ANGLE_KI = 3'd7
    } reg_index_t;

    localparam logic [GAIN_W-1:0] GAIN_RESET [NUM_REGS] = '{
        24'd204800, 24'd0, 24'd40960, 24'd246,
        24'd204800, 24'd0, 24'd40960, 24'd246
    };

    // command field: 0 attitude loop, 1 rate loop
    localparam logic CMD_RATE = 1'b1;

    typedef struct packed {
        logic accept;
        logic load2;
        logic load3;
        logic cmd0;
        logic cmd1;
        logic cmd2;
    } pipe_ctrl_t;

endpackage

// File: hw/rtl/dapi_if.sv
interface dapi_sample_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic signed [dapi_pkg::DATA_W-1:0]  roll_desired;
    logic signed [dapi_pkg::DATA_W-1:0]  roll_actual;
    logic signed [dapi_pkg::DATA_W-1:0]  pitch_desired;
    logic signed [dapi_pkg::DATA_W-1:0]  pitch_actual;

    modport source (output valid, command, roll_desired, roll_actual,
                    pitch_desired, pitch_actual, input ready);
    modport sink   (input valid, command, roll_desired, roll_actual,
                    pitch_desired, pitch_actual, output ready);
endinterface

interface dapi_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [dapi_pkg::DATA_W-1:0]  roll_out;
    logic signed [dapi_pkg::DATA_W-1:0]  pitch_out;

    modport source (output valid, roll_out, pitch_out, input ready);
    modport sink   (input valid, roll_out, pitch_out, output ready);
endinterface

// File: hw/rtl/dual_axis_incremental_pi_unit.sv
// Roll/pitch velocity-form PI controller. Each sample word updates both axes
// of the attitude loop (command 0) or the rate loop (command 1); one result
// word per sample. Throughput is one word per cycle while the result side
// keeps taking words. Three register stages: error stage (written at the
// accepting edge), gain multiply stage, then the accumulate/saturate stage
// that writes the output register. The accumulate-and-saturate step onto the
// previous output is the only per-loop recurrence. Gains must be written
// through cfg_we/cfg_index/cfg_data only while no sample is in flight; the
// block itself does not enforce this.
module dual_axis_incremental_pi_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dapi_pkg::IDX_W-1:0]          cfg_index,
    input  logic [dapi_pkg::GAIN_W-1:0]         cfg_data,
    dapi_sample_if.sink                         sample,
    dapi_result_if.source                       result
);

    logic [dapi_pkg::GAIN_W-1:0] gain_reg [dapi_pkg::NUM_REGS];

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic cmd1_reg, cmd2_reg;
    logic load2, load3, accept;
    dapi_pkg::pipe_ctrl_t ctrl;
    logic signed [dapi_pkg::DATA_W-1:0] roll_res, pitch_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < dapi_pkg::NUM_REGS; k++)
                gain_reg[k] <= dapi_pkg::GAIN_RESET[k];
        end
        else if (cfg_we)
            gain_reg[cfg_index] <= cfg_data;
    end

    assign load2        = v1_reg && (!v2_reg || load3);
    assign sample.ready = !v1_reg || load2;
    assign accept       = sample.valid && sample.ready;

    always_comb
    begin
        if (accept)
            v1_next = 1'b1;
        else if (load2)
            v1_next = 1'b0;
        else
            v1_next = v1_reg;
        if (load2)
            v2_next = 1'b1;
        else if (load3)
            v2_next = 1'b0;
        else
            v2_next = v2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd1_reg <= sample.command;
        if (load2)
            cmd2_reg <= cmd1_reg;
    end

    always_comb
    begin
        ctrl.accept = accept;
        ctrl.load2  = load2;
        ctrl.load3  = load3;
        ctrl.cmd0   = sample.command;
        ctrl.cmd1   = cmd1_reg;
        ctrl.cmd2   = cmd2_reg;
    end

    dapi_lane u_roll (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .desired  (sample.roll_desired),
        .actual   (sample.roll_actual),
        .rate_kp  (gain_reg[dapi_pkg::REG_ROLL_RATE_KP]),
        .rate_ki  (gain_reg[dapi_pkg::REG_ROLL_RATE_KI]),
        .angle_kp (gain_reg[dapi_pkg::REG_ROLL_ANGLE_KP]),
        .angle_ki (gain_reg[dapi_pkg::REG_ROLL_ANGLE_KI]),
        .res      (roll_res)
    );

    dapi_lane u_pitch (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .desired  (sample.pitch_desired),
        .actual   (sample.pitch_actual),
        .rate_kp  (gain_reg[dapi_pkg::REG_PITCH_RATE_KP]),
        .rate_ki  (gain_reg[dapi_pkg::REG_PITCH_RATE_KI]),
        .angle_kp (gain_reg[dapi_pkg::REG_PITCH_ANGLE_KP]),
        .angle_ki (gain_reg[dapi_pkg::REG_PITCH_ANGLE_KI]),
        .res      (pitch_res)
    );

    dapi_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (v2_reg),
        .roll_res    (roll_res),
        .pitch_res   (pitch_res),
        .load        (load3),
        .result      (result)
    );

endmodule

// File: hw/rtl/dapi_lane.sv
// One axis: error/difference, gain products, accumulate and saturate.
module dapi_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dapi_pkg::pipe_ctrl_t                ctrl,
    input  logic signed [dapi_pkg::DATA_W-1:0]  desired,
    input  logic signed [dapi_pkg::DATA_W-1:0]  actual,
    input  logic        [dapi_pkg::GAIN_W-1:0]  rate_kp,
    input  logic        [dapi_pkg::GAIN_W-1:0]  rate_ki,
    input  logic        [dapi_pkg::GAIN_W-1:0]  angle_kp,
    input  logic        [dapi_pkg::GAIN_W-1:0]  angle_ki,
    output logic signed [dapi_pkg::DATA_W-1:0]  res
);

    logic signed [dapi_pkg::ERR_W-1:0]    err;
    logic signed [dapi_pkg::ERR_W-1:0]    prev_err_sel;
    logic signed [dapi_pkg::DIFF_W-1:0]   diff_next;
    logic signed [dapi_pkg::ERR_W-1:0]    rate_err_reg;
    logic signed [dapi_pkg::ERR_W-1:0]    angle_err_reg;
    logic signed [dapi_pkg::DIFF_W-1:0]   diff_reg;
    logic signed [dapi_pkg::ERR_W-1:0]    pe_reg;

    logic        [dapi_pkg::GAIN_W-1:0]   kp_sel;
    logic        [dapi_pkg::GAIN_W-1:0]   ki_sel;
    logic signed [dapi_pkg::PROD_P_W-1:0] prod_p;
    logic signed [dapi_pkg::PROD_I_W-1:0] prod_i;
    logic signed [dapi_pkg::P_W-1:0]      p_reg;
    logic signed [dapi_pkg::I_W-1:0]      i_reg;

    logic signed [dapi_pkg::DRIVE_W-1:0]  drive_reg;
    logic signed [dapi_pkg::DATA_W-1:0]   angle_out_reg;
    logic signed [dapi_pkg::ERR_W-1:0]    prev_out;
    logic signed [dapi_pkg::SUM_W-1:0]    sum;
    logic signed [dapi_pkg::SUM_W-1:0]    adj;
    logic signed [dapi_pkg::SUM_W-dapi_pkg::Q_FRAC-1:0] q;
    logic signed [dapi_pkg::DRIVE_W-1:0]  drive_next;
    logic signed [dapi_pkg::DATA_W-1:0]   angle_out_next;

    // stage 1: error and difference against the selected loop's history
    assign err          = dapi_pkg::ERR_W'(desired) - dapi_pkg::ERR_W'(actual);
    assign prev_err_sel = (ctrl.cmd0 == dapi_pkg::CMD_RATE) ? rate_err_reg : angle_err_reg;
    assign diff_next    = dapi_pkg::DIFF_W'(err) - dapi_pkg::DIFF_W'(prev_err_sel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_err_reg  <= '0;
            angle_err_reg <= '0;
        end
        else if (ctrl.accept)
        begin
            if (ctrl.cmd0 == dapi_pkg::CMD_RATE)
                rate_err_reg <= err;
            else
                angle_err_reg <= err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            diff_reg <= diff_next;
            pe_reg   <= prev_err_sel;
        end
    end

    // stage 2: products, low 12 bits dropped (floor)
    assign kp_sel = (ctrl.cmd1 == dapi_pkg::CMD_RATE) ? rate_kp : angle_kp;
    assign ki_sel = (ctrl.cmd1 == dapi_pkg::CMD_RATE) ? rate_ki : angle_ki;
    assign prod_p = diff_reg * $signed({1'b0, kp_sel});
    assign prod_i = pe_reg * $signed({1'b0, ki_sel});

    always_ff @(posedge clk)
    begin
        if (ctrl.load2)
        begin
            p_reg <= prod_p[dapi_pkg::PROD_P_W-1:dapi_pkg::FRAC_W];
            i_reg <= prod_i[dapi_pkg::PROD_I_W-1:dapi_pkg::FRAC_W];
        end
    end

    // stage 3: accumulate onto previous output, saturate
    always_comb
    begin
        if (ctrl.cmd2 == dapi_pkg::CMD_RATE)
            prev_out = dapi_pkg::ERR_W'($signed({drive_reg, {dapi_pkg::Q_FRAC{1'b0}}}));
        else
            prev_out = dapi_pkg::ERR_W'(angle_out_reg);
        sum = dapi_pkg::SUM_W'(p_reg) + dapi_pkg::SUM_W'(i_reg)
            + dapi_pkg::SUM_W'(prev_out);
        // truncate toward zero
        adj = sum + (sum[dapi_pkg::SUM_W-1] ? dapi_pkg::ROUND_ADJ : '0);
        q   = adj[dapi_pkg::SUM_W-1:dapi_pkg::Q_FRAC];

        if (sum > dapi_pkg::OUT_MAX)
            angle_out_next = dapi_pkg::OUT_MAX[dapi_pkg::DATA_W-1:0];
        else if (sum < dapi_pkg::OUT_MIN)
            angle_out_next = dapi_pkg::OUT_MIN[dapi_pkg::DATA_W-1:0];
        else
            angle_out_next = sum[dapi_pkg::DATA_W-1:0];

        if (dapi_pkg::SUM_W'(q) > dapi_pkg::DRIVE_MAX)
            drive_next = dapi_pkg::DRIVE_MAX[dapi_pkg::DRIVE_W-1:0];
        else if (dapi_pkg::SUM_W'(q) < dapi_pkg::DRIVE_MIN)
            drive_next = dapi_pkg::DRIVE_MIN[dapi_pkg::DRIVE_W-1:0];
        else
            drive_next = q[dapi_pkg::DRIVE_W-1:0];

        if (ctrl.cmd2 == dapi_pkg::CMD_RATE)
            res = dapi_pkg::DATA_W'(drive_next);
        else
            res = angle_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg     <= '0;
            angle_out_reg <= '0;
        end
        else if (ctrl.load3)
        begin
            if (ctrl.cmd2 == dapi_pkg::CMD_RATE)
                drive_reg <= drive_next;
            else
                angle_out_reg <= angle_out_next;
        end
    end

endmodule

// File: hw/rtl/dapi_merge.sv
// Output register joining both lanes into one result word.
module dapi_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                stage_valid,
    input  logic signed [dapi_pkg::DATA_W-1:0]  roll_res,
    input  logic signed [dapi_pkg::DATA_W-1:0]  pitch_res,
    output logic                                load,
    dapi_result_if.source                       result
);

    logic                               valid_reg;
    logic                               valid_next;
    logic signed [dapi_pkg::DATA_W-1:0] roll_reg;
    logic signed [dapi_pkg::DATA_W-1:0] pitch_reg;

    assign load = stage_valid && (!valid_reg || result.ready);

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (result.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            roll_reg  <= roll_res;
            pitch_reg <= pitch_res;
        end
    end

    assign result.valid     = valid_reg;
    assign result.roll_out  = roll_reg;
    assign result.pitch_out = pitch_reg;

endmodule

// File: hw/rtl/dapi_checker.sv
`include "dual_axis_incremental_pi_unit_macros.svh"

module dapi_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                sample_valid,
    input logic                                sample_ready,
    input logic                                result_valid,
    input logic                                result_ready,
    input logic signed [dapi_pkg::DATA_W-1:0]  roll_out,
    input logic signed [dapi_pkg::DATA_W-1:0]  pitch_out
);

    // with nothing waiting at the output the pipe can always take a word
    `DAPI_ASSERT_IMP(a_ready_when_out_empty, clk, rst_n, !result_valid, sample_ready)

    // an accepted word reaches the output when the sink keeps taking
    `DAPI_ASSERT_NXT(a_latency, clk, rst_n,
        (sample_valid && sample_ready) ##1 result_ready ##1 result_ready, result_valid)

    `DAPI_ASSERT_NXT(a_out_hold, clk, rst_n, result_valid && !result_ready, result_valid)

    `DAPI_ASSERT_NXT(a_out_stable, clk, rst_n, result_valid && !result_ready,
        $stable(roll_out) && $stable(pitch_out))

endmodule

bind dual_axis_incremental_pi_unit dapi_checker u_dapi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .roll_out     (result.roll_out),
    .pitch_out    (result.pitch_out)
);

// File: sim/dual_axis_incremental_pi_unit_test.sv
typedef logic signed [dapi_pkg::DATA_W-1:0] q8_t;

typedef struct packed {
    q8_t roll;
    q8_t pitch;
} pi_word_t;

class pi_scoreboard;
    logic [dapi_pkg::GAIN_W-1:0]      gain [dapi_pkg::NUM_REGS];
    // index 0 roll, 1 pitch
    logic signed [dapi_pkg::ERR_W-1:0]   rate_err [2];
    logic signed [dapi_pkg::DRIVE_W-1:0] rate_drive [2];
    logic signed [dapi_pkg::ERR_W-1:0]   angle_err [2];
    q8_t                                 angle_out [2];
    pi_word_t                            expected_words [$];
    int                                  mismatches;

    function new();
        for (int k = 0; k < dapi_pkg::NUM_REGS; k++)
            gain[k] = dapi_pkg::GAIN_RESET[k];
        for (int a = 0; a < 2; a++)
        begin
            rate_err[a] = '0;
            rate_drive[a] = '0;
            angle_err[a] = '0;
            angle_out[a] = '0;
        end
        mismatches = 0;
    endfunction

    function void set_gain(dapi_pkg::reg_index_t idx, logic [dapi_pkg::GAIN_W-1:0] value);
        gain[idx] = value;
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    // Q.8 times Q12.12, low 12 bits dropped (floor)
    function longint scale_by_gain(longint x, logic [dapi_pkg::GAIN_W-1:0] g);
        longint gl;
        gl = longint'(g);
        return (x * gl) >>> dapi_pkg::FRAC_W;
    endfunction

    function longint clamp(longint x, longint lo, longint hi);
        if (x > hi)
            return hi;
        if (x < lo)
            return lo;
        return x;
    endfunction

    function longint pi_increment(bit rate_loop, int axis, longint e);
        dapi_pkg::reg_index_t kp_idx;
        dapi_pkg::reg_index_t ki_idx;
        longint prev;
        longint incr;
        if (rate_loop)
        begin
            kp_idx = axis ? dapi_pkg::REG_PITCH_RATE_KP : dapi_pkg::REG_ROLL_RATE_KP;
            ki_idx = axis ? dapi_pkg::REG_PITCH_RATE_KI : dapi_pkg::REG_ROLL_RATE_KI;
            prev = longint'(rate_err[axis]);
            rate_err[axis] = e[dapi_pkg::ERR_W-1:0];
        end
        else
        begin
            kp_idx = axis ? dapi_pkg::REG_PITCH_ANGLE_KP : dapi_pkg::REG_ROLL_ANGLE_KP;
            ki_idx = axis ? dapi_pkg::REG_PITCH_ANGLE_KI : dapi_pkg::REG_ROLL_ANGLE_KI;
            prev = longint'(angle_err[axis]);
            angle_err[axis] = e[dapi_pkg::ERR_W-1:0];
        end
        incr = scale_by_gain(e - prev, gain[kp_idx]) + scale_by_gain(prev, gain[ki_idx]);
        return incr;
    endfunction

    function void note_sample(logic cmd, q8_t rd, q8_t ra, q8_t pd, q8_t pa);
        longint   e [2];
        longint   s;
        longint   q;
        q8_t      outv [2];
        pi_word_t w;
        e[0] = longint'(rd) - longint'(ra);
        e[1] = longint'(pd) - longint'(pa);
        for (int a = 0; a < 2; a++)
        begin
            if (cmd == dapi_pkg::CMD_RATE)
            begin
                s = longint'(rate_drive[a]) * 256 + pi_increment(1'b1, a, e[a]);
                // integer part, truncated toward zero
                q = (s >= 0) ? (s >>> dapi_pkg::Q_FRAC) : -((-s) >>> dapi_pkg::Q_FRAC);
                q = clamp(q, -32767, 32767);
                rate_drive[a] = q[dapi_pkg::DRIVE_W-1:0];
            end
            else
            begin
                s = longint'(angle_out[a]) + pi_increment(1'b0, a, e[a]);
                q = clamp(s, -8388608, 8388607);
                angle_out[a] = q[dapi_pkg::DATA_W-1:0];
            end
            outv[a] = q[dapi_pkg::DATA_W-1:0];
        end
        w.roll = outv[0];
        w.pitch = outv[1];
        expected_words.push_back(w);
    endfunction

    function void flag(string what, longint expv, longint actv);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, expv, actv);
    endfunction

    function void check_result(q8_t roll, q8_t pitch);
        pi_word_t w;
        if (expected_words.size() == 0)
        begin
            flag("unexpected word, roll", 0, roll);
            return;
        end
        w = expected_words.pop_front();
        if (w.roll !== roll)
            flag("roll_out", w.roll, roll);
        if (w.pitch !== pitch)
            flag("pitch_out", w.pitch, pitch);
    endfunction
endclass

module dual_axis_incremental_pi_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_ATTITUDE = ~dapi_pkg::CMD_RATE;
    localparam q8_t  FIELD_MAX = 24'sh7FFFFF;
    localparam q8_t  FIELD_MIN = 24'sh800000;
    localparam int   CYCLE_LIMIT = 300000;
    localparam int   ITEMS_PER_PHASE = 80;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [dapi_pkg::IDX_W-1:0]    cfg_index;
    logic [dapi_pkg::GAIN_W-1:0]   cfg_data;
    logic [dapi_pkg::GAIN_W-1:0]   gain_plan [dapi_pkg::NUM_REGS];
    bit                            tx_gaps_on;
    bit                            rx_gaps_on;
    int                            stall_left;
    int                            cycle_count;

    pi_scoreboard sb = new();

    dapi_sample_if sample_ch ();
    dapi_result_if result_ch ();

    dual_axis_incremental_pi_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    always #2 clk = ~clk;

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic q8_t pick_value();
        case ($urandom_range(0, 7))
            0, 1: return q8_t'($urandom);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return FIELD_MAX;
                    1: return FIELD_MIN;
                    2: return '0;
                    default: return -24'sd1;
                endcase
            end
            default: return q8_t'(int'($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    function automatic logic [dapi_pkg::GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return '0;
            2, 3: return dapi_pkg::GAIN_W'($urandom_range(0, 262143));
            default: return dapi_pkg::GAIN_W'($urandom);
        endcase
    endfunction

    task automatic load_gains();
        for (int k = 0; k < dapi_pkg::NUM_REGS; k++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= dapi_pkg::reg_index_t'(k);
            cfg_data <= gain_plan[k];
            @(posedge clk);
            sb.set_gain(dapi_pkg::reg_index_t'(k), gain_plan[k]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_sample(logic cmd, q8_t rd, q8_t ra, q8_t pd, q8_t pa);
        int gap;
        gap = pick_gap(tx_gaps_on);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.command <= cmd;
        sample_ch.roll_desired <= rd;
        sample_ch.roll_actual <= ra;
        sample_ch.pitch_desired <= pd;
        sample_ch.pitch_actual <= pa;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        sb.note_sample(cmd, rd, ra, pd, pa);
    endtask

    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // result side: check every accepted word, stall ready at random
    initial
    begin
        result_ch.ready <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.roll_out, result_ch.pitch_out);
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                stall_left = pick_gap(rx_gaps_on);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.command <= CMD_ATTITUDE;
        sample_ch.roll_desired <= '0;
        sample_ch.roll_actual <= '0;
        sample_ch.pitch_desired <= '0;
        sample_ch.pitch_actual <= '0;
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words on the reset gains
        send_sample(CMD_ATTITUDE, '0, '0, '0, '0);
        send_sample(dapi_pkg::CMD_RATE, '0, '0, '0, '0);
        // attitude saturation both ways, then recovery
        send_sample(CMD_ATTITUDE, FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MAX);
        send_sample(CMD_ATTITUDE, FIELD_MIN, FIELD_MAX, FIELD_MAX, FIELD_MIN);
        send_sample(CMD_ATTITUDE, '0, '0, '0, '0);
        // drive saturation, held, then reversed
        send_sample(dapi_pkg::CMD_RATE, FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MAX);
        send_sample(dapi_pkg::CMD_RATE, FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MAX);
        send_sample(dapi_pkg::CMD_RATE, FIELD_MIN, FIELD_MAX, FIELD_MAX, FIELD_MIN);
        // small errors: truncation toward zero of negative drive sums
        send_sample(dapi_pkg::CMD_RATE, '0, '0, '0, '0);
        send_sample(dapi_pkg::CMD_RATE, -24'sd1, '0, '0, -24'sd1);
        send_sample(dapi_pkg::CMD_RATE, '0, 24'sd1, 24'sd1, '0);
        send_sample(CMD_ATTITUDE, -24'sd1, '0, 24'sd1, '0);
        send_sample(CMD_ATTITUDE, 24'sd1, 24'sd1, -24'sd256, 24'sd256);
        send_sample(dapi_pkg::CMD_RATE, 24'sd256, -24'sd256, -24'sd3, 24'sd5);
        send_sample(CMD_ATTITUDE, FIELD_MAX, FIELD_MAX, FIELD_MIN, FIELD_MIN);
        send_sample(dapi_pkg::CMD_RATE, 24'sh555555, 24'sh2AAAAA, 24'shAAAAAA,
                    24'sh555555);
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            for (int k = 0; k < dapi_pkg::NUM_REGS; k++)
            begin
                case (ph)
                    0: gain_plan[k] = '1;
                    1: gain_plan[k] = '0;
                    7: gain_plan[k] = dapi_pkg::GAIN_RESET[k];
                    default: gain_plan[k] = pick_gain();
                endcase
            end
            load_gains();
            // every pairing of sender gaps and receiver stalls, twice
            tx_gaps_on = ph[0];
            rx_gaps_on = ph[1];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_sample(logic'($urandom_range(0, 1)), pick_value(), pick_value(),
                            pick_value(), pick_value());
            wait_drained();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
